// File: hw/rtl/ttip_pkg.sv
// ----------------------------------------------------------------------------
// ttip_pkg: shared types and constants for the text-to-integer parser
// Character classes, queue entry type, register indexes and radix codes.
// ----------------------------------------------------------------------------
`default_nettype none

package ttip_pkg;

	// configuration register indexes
	localparam int CFG_IDX_BITS = 2;
	localparam logic [CFG_IDX_BITS-1:0] REG_RADIX       = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SIGNED_MODE = 2'd1;

	localparam int RADIX_BITS = 6;
	localparam logic [RADIX_BITS-1:0] RADIX_AUTO = 6'd0;
	localparam logic [RADIX_BITS-1:0] RADIX_MIN  = 6'd2;
	localparam logic [RADIX_BITS-1:0] RADIX_BIN  = 6'd2;
	localparam logic [RADIX_BITS-1:0] RADIX_OCT  = 6'd8;
	localparam logic [RADIX_BITS-1:0] RADIX_DEC  = 6'd10;
	localparam logic [RADIX_BITS-1:0] RADIX_HEX  = 6'd16;
	localparam logic [RADIX_BITS-1:0] RADIX_MAX  = 6'd36;

	// character codes
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS  = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO  = 8'h30;
	localparam logic [7:0] CH_NINE  = 8'h39;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_B  = 8'h42;
	localparam logic [7:0] CH_UC_X  = 8'h58;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;
	localparam logic [7:0] CH_LC_A  = 8'h61;
	localparam logic [7:0] CH_LC_B  = 8'h62;
	localparam logic [7:0] CH_LC_X  = 8'h78;
	localparam logic [7:0] CH_LC_Z  = 8'h7A;
	localparam logic [7:0] UC_BIAS  = 8'h37; // 'A' - 10
	localparam logic [7:0] LC_BIAS  = 8'h57; // 'a' - 10

	// decoupling queue between classifier and parser core
	localparam int QDEPTH    = 4;
	localparam int QPTR_BITS = 2;
	localparam int QCNT_BITS = 3;

	// one classified character
	typedef struct packed {
		logic                  first;
		logic                  is_space;
		logic                  is_sign;
		logic                  is_minus;
		logic                  is_zero;
		logic                  is_x;
		logic                  is_b;
		logic                  dv_ok;
		logic [RADIX_BITS-1:0] dv;
	} ttip_char_t;

endpackage

`default_nettype wire

// File: hw/rtl/ttip_front.sv
// ----------------------------------------------------------------------------
// ttip_front: character classifier
// Accepts input transfers and decodes each byte into a class record.
// ----------------------------------------------------------------------------
`default_nettype none

module ttip_front (
	input  wire logic              in_valid,
	output logic                   in_stall,
	input  wire logic              first_char,
	input  wire logic [7:0]        char_code,
	input  wire logic              q_full,
	output logic                   push,
	output ttip_pkg::ttip_char_t   item
);
	import ttip_pkg::*;

	logic [7:0] c;
	logic [7:0] dsub;

	assign c        = char_code;
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		dsub          = 8'd0;
		item.dv_ok    = 1'b0;
		if (c >= CH_ZERO && c <= CH_NINE) begin
			dsub       = c - CH_ZERO;
			item.dv_ok = 1'b1;
		end else if (c >= CH_UC_A && c <= CH_UC_Z) begin
			dsub       = c - UC_BIAS;
			item.dv_ok = 1'b1;
		end else if (c >= CH_LC_A && c <= CH_LC_Z) begin
			dsub       = c - LC_BIAS;
			item.dv_ok = 1'b1;
		end
		item.dv       = dsub[RADIX_BITS-1:0];
		item.first    = first_char;
		item.is_space = (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
		item.is_sign  = (c == CH_PLUS) || (c == CH_MINUS);
		item.is_minus = (c == CH_MINUS);
		item.is_zero  = (c == CH_ZERO);
		item.is_x     = (c == CH_LC_X) || (c == CH_UC_X);
		item.is_b     = (c == CH_LC_B) || (c == CH_UC_B);
	end

endmodule

`default_nettype wire

// File: hw/rtl/ttip_queue.sv
// ----------------------------------------------------------------------------
// ttip_queue: short FIFO between classifier and parser core
// Register-based queue, one push and one pop per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ttip_queue (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 push,
	input  wire ttip_pkg::ttip_char_t push_item,
	output logic                      full,
	input  wire logic                 pop,
	output logic                      head_valid,
	output ttip_pkg::ttip_char_t      head_item
);
	import ttip_pkg::*;

	ttip_char_t             mem_q [QDEPTH];
	logic [QPTR_BITS-1:0]   wr_ptr_q;
	logic [QPTR_BITS-1:0]   rd_ptr_q;
	logic [QCNT_BITS-1:0]   count_q;

	assign full       = (count_q == QCNT_BITS'(QDEPTH));
	assign head_valid = (count_q != '0);
	assign head_item  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("pop from empty queue");
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCNT_BITS'(QDEPTH))
		else $error("queue count beyond depth");

endmodule

`default_nettype wire

// File: hw/rtl/ttip_back.sv
// ----------------------------------------------------------------------------
// ttip_back: parser core
// Runs the parse state machine, one multiply-add per digit, output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ttip_back #(
	parameter int WORD_BITS   = 32,
	parameter int OFFSET_BITS = 16
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              q_valid,
	input  wire ttip_pkg::ttip_char_t              q_item,
	output logic                                   q_pop,
	input  wire logic [ttip_pkg::RADIX_BITS-1:0]   radix,
	input  wire logic                              signed_mode,
	output logic                                   out_valid,
	input  wire logic                              out_stall,
	output logic [WORD_BITS-1:0]                   value,
	output logic                                   overflow,
	output logic                                   no_digits,
	output logic [OFFSET_BITS-1:0]                 end_offset
);
	import ttip_pkg::*;

	localparam int PW = WORD_BITS + RADIX_BITS + 1;

	localparam logic [2:0] PH_IDLE   = 3'd0;
	localparam logic [2:0] PH_SPACE  = 3'd1;
	localparam logic [2:0] PH_SIGN   = 3'd2;
	localparam logic [2:0] PH_ZERO   = 3'd3;
	localparam logic [2:0] PH_PREFIX = 3'd4;
	localparam logic [2:0] PH_DIGITS = 3'd5;

	logic [2:0]             phase_q;
	logic [WORD_BITS-1:0]   acc_q;
	logic                   neg_q;
	logic                   ovf_q;
	logic                   seen_q;
	logic [RADIX_BITS-1:0]  arad_q;
	logic [OFFSET_BITS-1:0] pos_q;
	logic [OFFSET_BITS-1:0] pfx_q;

	logic                   out_valid_q;
	logic [WORD_BITS-1:0]   value_q;
	logic                   overflow_q;
	logic                   no_digits_q;
	logic [OFFSET_BITS-1:0] end_offset_q;

	// state as seen by the current character (after a restart, if any)
	logic [2:0]             ph_cur;
	logic [WORD_BITS-1:0]   acc_cur;
	logic                   neg_cur;
	logic                   ovf_cur;
	logic                   seen_cur;
	logic [RADIX_BITS-1:0]  ar_cur;
	logic [OFFSET_BITS-1:0] pos_cur;

	logic [2:0]             ph_n;
	logic [WORD_BITS-1:0]   acc_n;
	logic                   neg_n;
	logic                   ovf_n;
	logic                   seen_n;
	logic [RADIX_BITS-1:0]  ar_n;
	logic [OFFSET_BITS-1:0] pfx_n;

	logic                   fire;
	logic [RADIX_BITS-1:0]  r_eff;
	logic                   dok;
	logic [WORD_BITS-1:0]   base;
	logic [PW-1:0]          prod;
	logic [PW-1:0]          lim;
	logic                   add_ovf;
	logic [WORD_BITS-1:0]   add_acc;
	logic [WORD_BITS-1:0]   sat_val;
	logic [WORD_BITS-1:0]   fin_val;
	logic                   do_take;
	logic                   do_start;
	logic                   do_emit;
	logic [WORD_BITS-1:0]   em_val;
	logic                   em_ovf;
	logic                   em_nod;
	logic [OFFSET_BITS-1:0] em_end;

	assign fire  = q_valid && !(out_valid_q && out_stall);
	assign q_pop = fire;

	// restart on a first character, otherwise bump the position
	always_comb begin
		if (q_item.first) begin
			ph_cur   = PH_SPACE;
			acc_cur  = '0;
			neg_cur  = 1'b0;
			ovf_cur  = 1'b0;
			seen_cur = 1'b0;
			ar_cur   = radix;
			pos_cur  = '0;
		end else begin
			ph_cur   = phase_q;
			acc_cur  = acc_q;
			neg_cur  = neg_q;
			ovf_cur  = ovf_q;
			seen_cur = seen_q;
			ar_cur   = arad_q;
			pos_cur  = (phase_q != PH_IDLE && pos_q != '1) ? pos_q + 1'b1 : pos_q;
		end
	end

	// radix in force for a digit taken in this phase
	always_comb begin
		unique case (ph_cur) inside
			PH_SPACE, PH_SIGN: r_eff = (ar_cur == RADIX_AUTO) ? RADIX_DEC : ar_cur;
			PH_ZERO:           r_eff = (ar_cur == RADIX_AUTO) ? RADIX_OCT : ar_cur;
			default:           r_eff = ar_cur;
		endcase
	end

	assign dok = q_item.dv_ok && r_eff >= RADIX_MIN && r_eff <= RADIX_MAX
	          && q_item.dv < r_eff;

	// multiply-add with range check against the live limit
	assign base = (ph_cur == PH_PREFIX) ? '0 : acc_cur;
	assign prod = ({{(RADIX_BITS+1){1'b0}}, base} * {{(WORD_BITS+1){1'b0}}, r_eff})
	            + {{(WORD_BITS+1){1'b0}}, q_item.dv};

	always_comb begin
		if (signed_mode) begin
			lim = neg_cur ? PW'({1'b1, {(WORD_BITS-1){1'b0}}})
			              : PW'({1'b0, {(WORD_BITS-1){1'b1}}});
		end else begin
			lim = PW'({WORD_BITS{1'b1}});
		end
	end

	assign add_ovf = ovf_cur || (prod > lim);
	assign add_acc = add_ovf ? base : prod[WORD_BITS-1:0];

	always_comb begin
		if (signed_mode) begin
			sat_val = neg_cur ? {1'b1, {(WORD_BITS-1){1'b0}}}
			                  : {1'b0, {(WORD_BITS-1){1'b1}}};
		end else begin
			sat_val = '1;
		end
		if (ovf_cur) begin
			fin_val = sat_val;
		end else if (neg_cur) begin
			fin_val = '0 - acc_cur;
		end else begin
			fin_val = acc_cur;
		end
	end

	// parse state machine
	always_comb begin
		ph_n     = ph_cur;
		acc_n    = acc_cur;
		neg_n    = neg_cur;
		ovf_n    = ovf_cur;
		seen_n   = seen_cur;
		ar_n     = ar_cur;
		pfx_n    = pfx_q;
		do_take  = 1'b0;
		do_start = 1'b0;
		do_emit  = 1'b0;
		em_val   = '0;
		em_ovf   = 1'b0;
		em_nod   = 1'b0;
		em_end   = '0;

		unique case (ph_cur)
			PH_IDLE: begin
			end
			PH_SPACE: begin
				if (q_item.is_space) begin
					ph_n = PH_SPACE;
				end else if (q_item.is_sign) begin
					neg_n = q_item.is_minus;
					ph_n  = PH_SIGN;
				end else begin
					do_start = 1'b1;
				end
			end
			PH_SIGN: begin
				do_start = 1'b1;
			end
			PH_ZERO: begin
				if (q_item.is_x && (ar_cur == RADIX_AUTO || ar_cur == RADIX_HEX)) begin
					ar_n  = RADIX_HEX;
					pfx_n = pos_cur;
					ph_n  = PH_PREFIX;
				end else if (q_item.is_b && (ar_cur == RADIX_AUTO || ar_cur == RADIX_BIN)) begin
					ar_n  = RADIX_BIN;
					pfx_n = pos_cur;
					ph_n  = PH_PREFIX;
				end else begin
					ar_n    = r_eff;
					do_take = 1'b1;
				end
			end
			PH_PREFIX: begin
				if (dok) begin
					do_take = 1'b1;
				end else begin
					// dangling prefix: the lone zero is the number
					do_emit = 1'b1;
					em_end  = pfx_q;
				end
			end
			PH_DIGITS: begin
				do_take = 1'b1;
			end
			default: begin
				ph_n = PH_IDLE;
			end
		endcase

		if (do_start) begin
			if (q_item.is_zero && (ar_cur == RADIX_AUTO || ar_cur == RADIX_BIN
			    || ar_cur == RADIX_HEX)) begin
				seen_n = 1'b1;
				acc_n  = '0;
				ph_n   = PH_ZERO;
			end else begin
				ar_n    = r_eff;
				do_take = 1'b1;
			end
		end

		if (do_take) begin
			if (dok) begin
				acc_n  = add_acc;
				ovf_n  = add_ovf;
				seen_n = 1'b1;
				ph_n   = PH_DIGITS;
			end else begin
				do_emit = 1'b1;
				em_nod  = !seen_cur;
				em_ovf  = seen_cur && ovf_cur;
				em_val  = seen_cur ? fin_val : '0;
				em_end  = seen_cur ? pos_cur : '0;
			end
		end

		if (do_emit) begin
			ph_n = PH_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			acc_q   <= '0;
			neg_q   <= 1'b0;
			ovf_q   <= 1'b0;
			seen_q  <= 1'b0;
			arad_q  <= '0;
			pos_q   <= '0;
			pfx_q   <= '0;
		end else if (fire) begin
			phase_q <= ph_n;
			acc_q   <= acc_n;
			neg_q   <= neg_n;
			ovf_q   <= ovf_n;
			seen_q  <= seen_n;
			arad_q  <= ar_n;
			pos_q   <= pos_cur;
			pfx_q   <= pfx_n;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire && do_emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire && do_emit) begin
			value_q      <= em_val;
			overflow_q   <= em_ovf;
			no_digits_q  <= em_nod;
			end_offset_q <= em_end;
		end
	end

	assign out_valid  = out_valid_q;
	assign value      = value_q;
	assign overflow   = overflow_q;
	assign no_digits  = no_digits_q;
	assign end_offset = end_offset_q;

	a_digits_seen: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_DIGITS || phase_q == PH_ZERO) |-> seen_q)
		else $error("digit phase without a digit");
	a_ovf_seen: assert property (@(posedge clk) disable iff (!arst_n)
		ovf_q |-> seen_q)
		else $error("overflow without a digit");
	a_prefix_radix: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_PREFIX) |-> (arad_q == RADIX_HEX || arad_q == RADIX_BIN))
		else $error("prefix phase with wrong radix");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> $stable(value_q) && $stable(end_offset_q))
		else $error("pending result overwritten");

endmodule

`default_nettype wire

// File: hw/rtl/text_to_integer_parser.sv
// ----------------------------------------------------------------------------
// text_to_integer_parser: streaming string-to-integer parser
// Classifier, short queue and parser core; strtol / strtoul semantics.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake              payload
//  -------   ---------  ---------------------  ----------------------------------
//  in        sink       in_valid / in_stall    first_char, char_code
//  out       source     out_valid / out_stall  value, overflow, no_digits,
//                                              end_offset
//  cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
//  One character per cycle sustained while no result waits under out_stall;
//  the parser core does one multiply-add by the radix per digit, which is
//  the critical path. A character reaches the core through the queue
//  registers; the result appears in the output register the cycle after the
//  ending char. Reset (arst_n low, asynchronous) empties the queue, idles the
//  parser and loads radix = 0, signed_mode = 1.
//  in_stall rises only when the four-entry queue is full; the core stops only
//  while a finished result waits under out_stall.
// ----------------------------------------------------------------------------
`default_nettype none

module text_to_integer_parser #(
	parameter int WORD_BITS   = 32,
	parameter int OFFSET_BITS = 16
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// character input
	input  wire logic                                in_valid,
	output logic                                     in_stall,
	input  wire logic                                first_char,
	input  wire logic [7:0]                          char_code,
	// result output
	output logic                                     out_valid,
	input  wire logic                                out_stall,
	output logic [WORD_BITS-1:0]                     value,
	output logic                                     overflow,
	output logic                                     no_digits,
	output logic [OFFSET_BITS-1:0]                   end_offset,
	// configuration writes
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [ttip_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [ttip_pkg::RADIX_BITS-1:0]     cfg_data
);
	import ttip_pkg::*;

	logic [RADIX_BITS-1:0] radix_q;
	logic                  signed_mode_q;

	logic       push;
	ttip_char_t push_item;
	logic       q_full;
	logic       q_pop;
	logic       q_valid;
	ttip_char_t q_item;

	// configuration registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q       <= RADIX_AUTO;
			signed_mode_q <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_RADIX:       radix_q       <= cfg_data;
				REG_SIGNED_MODE: signed_mode_q <= cfg_data[0];
				default: begin
				end
			endcase
		end
	end

	// front: take each transfer and classify the byte
	ttip_front u_front (
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.first_char (first_char),
		.char_code  (char_code),
		.q_full     (q_full),
		.push       (push),
		.item       (push_item)
	);

	// decoupling queue
	ttip_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_item  (push_item),
		.full       (q_full),
		.pop        (q_pop),
		.head_valid (q_valid),
		.head_item  (q_item)
	);

	// back: parse state, accumulate, saturate, emit
	ttip_back #(
		.WORD_BITS   (WORD_BITS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_item      (q_item),
		.q_pop       (q_pop),
		.radix       (radix_q),
		.signed_mode (signed_mode_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.value       (value),
		.overflow    (overflow),
		.no_digits   (no_digits),
		.end_offset  (end_offset)
	);

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for text_to_integer_parser
// Streams character strings through the parser under a range of radix and
// sign settings. Every accepted character is run through a local parser
// model, and each result transfer is checked field by field against it.
// ----------------------------------------------------------------------------

module tb_top;
	import ttip_pkg::*;

	localparam logic [7:0] CH_NUL = 8'h00;
	localparam int WD_LIMIT     = 2000; // quiet cycles before declaring a hang
	localparam int DRAIN_CYCLES = 16;   // queue depth plus core latency, with margin
	localparam int HOLD_CYCLES  = 150;  // long receiver hold-off
	localparam int NUM_PHASES   = 15;
	localparam int PHASE_ITEMS  = 22;

	// one character as offered on the input channel
	typedef struct packed {
		logic       first;
		logic [7:0] code;
	} char_item_t;

	// one parse result as seen on the output channel
	typedef struct packed {
		logic [31:0] value;
		logic        overflow;
		logic        no_digits;
		logic [15:0] end_offset;
	} parse_result_t;

	// parser phases of the local model
	typedef enum logic [2:0] {
		P_IDLE, P_SPACE, P_SIGN, P_ZERO, P_PREFIX, P_DIGITS
	} parse_phase_e;

	// ------------------------------------------------------------------------
	// clock, reset, DUT ports
	// ------------------------------------------------------------------------
	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	logic                    in_valid   = 1'b0;
	logic                    in_stall;
	logic                    first_char = 1'b0;
	logic [7:0]              char_code  = '0;
	logic                    out_valid;
	logic                    out_stall  = 1'b0;
	logic [31:0]             value;
	logic                    overflow;
	logic                    no_digits;
	logic [15:0]             end_offset;
	logic                    cfg_valid  = 1'b0;
	logic                    cfg_ready;
	logic [CFG_IDX_BITS-1:0] cfg_index  = '0;
	logic [RADIX_BITS-1:0]   cfg_data   = '0;

	always #5 clk = ~clk;

	text_to_integer_parser i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.first_char (first_char),
		.char_code  (char_code),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.value      (value),
		.overflow   (overflow),
		.no_digits  (no_digits),
		.end_offset (end_offset),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	// ------------------------------------------------------------------------
	// bench state
	// ------------------------------------------------------------------------
	char_item_t    char_q[$];           // characters waiting to be driven
	parse_result_t expected_results[$]; // predicted results, oldest first
	parse_result_t want;
	char_item_t    nxt;
	int            mismatches   = 0;
	int            string_items = 0;    // characters of generated numbers
	logic          idle_en      = 1'b1; // random gaps / stalls on or off
	int            hold_asks    = 0;    // bumped to request a long hold-off
	int            hold_seen    = 0;
	int            hold_cnt     = 0;
	int            in_gap       = 0;
	int            out_gap      = 0;

	// register copies as the model sees them (reset values)
	logic [5:0] radix_reg  = RADIX_AUTO;
	logic       signed_reg = 1'b1;

	// parser model state
	parse_phase_e ps_phase = P_IDLE;
	logic [31:0]  ps_acc   = '0;
	logic         ps_neg   = 1'b0;
	logic         ps_ovf   = 1'b0;
	logic         ps_seen  = 1'b0;
	logic [5:0]   ps_radix = '0;
	logic [15:0]  ps_pos   = '0;

	// ------------------------------------------------------------------------
	// parser model
	// ------------------------------------------------------------------------

	// weight of a character as a digit; 99 for anything that is not 0-9/A-Z/a-z
	function automatic int digit_val(logic [7:0] c);
		if (c >= CH_ZERO && c <= CH_NINE) begin
			return int'(c - CH_ZERO);
		end
		if (c >= CH_UC_A && c <= CH_UC_Z) begin
			return int'(c - UC_BIAS);
		end
		if (c >= CH_LC_A && c <= CH_LC_Z) begin
			return int'(c - LC_BIAS);
		end
		return 99;
	endfunction

	// valid digit for the current base; bases 0, 1 and above 36 take none
	function automatic bit is_digit(logic [7:0] c);
		return ps_radix >= RADIX_MIN && ps_radix <= RADIX_MAX && digit_val(c) < ps_radix;
	endfunction

	// multiply-add with saturation check against the live sign mode
	function automatic void accumulate(int d);
		longint unsigned lim;
		longint unsigned cut;
		longint unsigned cutlim;
		if (!signed_reg) begin
			lim = 64'hFFFF_FFFF;
		end else if (ps_neg) begin
			lim = 64'h8000_0000;
		end else begin
			lim = 64'h7FFF_FFFF;
		end
		cut    = lim / ps_radix;
		cutlim = lim % ps_radix;
		ps_seen = 1'b1;
		if (!ps_ovf) begin
			if (ps_acc > cut || (ps_acc == cut && longint'(d) > cutlim)) begin
				ps_ovf = 1'b1;
			end else begin
				ps_acc = 32'(longint'(ps_acc) * ps_radix + d);
			end
		end
	endfunction

	function automatic void post_result(logic [31:0] v, logic o, logic nd, logic [15:0] e);
		parse_result_t r;
		r.value      = v;
		r.overflow   = o;
		r.no_digits  = nd;
		r.end_offset = e;
		expected_results.push_back(r);
		ps_phase = P_IDLE;
	endfunction

	function automatic void close_number();
		logic [31:0] v;
		if (!ps_seen) begin
			post_result('0, 1'b0, 1'b1, '0);
		end else begin
			if (ps_ovf) begin
				if (!signed_reg) begin
					v = 32'hFFFF_FFFF;
				end else begin
					v = ps_neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
				end
			end else begin
				v = ps_neg ? -ps_acc : ps_acc;
			end
			post_result(v, ps_ovf, 1'b0, ps_pos);
		end
	endfunction

	function automatic void digit_or_end(logic [7:0] c);
		if (is_digit(c)) begin
			accumulate(digit_val(c));
			ps_phase = P_DIGITS;
		end else begin
			close_number();
		end
	endfunction

	// first character after whitespace/sign; a lone 0 may open a prefix
	function automatic void begin_number(logic [7:0] c);
		if (c == CH_ZERO &&
		    (ps_radix == RADIX_AUTO || ps_radix == RADIX_BIN || ps_radix == RADIX_HEX)) begin
			ps_seen  = 1'b1;
			ps_acc   = '0;
			ps_phase = P_ZERO;
		end else begin
			if (ps_radix == RADIX_AUTO) begin
				ps_radix = RADIX_DEC;
			end
			digit_or_end(c);
		end
	endfunction

	// advance the model by one accepted character
	function automatic void predict_char(logic first, logic [7:0] c);
		if (first) begin
			ps_phase = P_SPACE;
			ps_acc   = '0;
			ps_neg   = 1'b0;
			ps_ovf   = 1'b0;
			ps_seen  = 1'b0;
			ps_radix = radix_reg;  // radix is sampled once per string
			ps_pos   = '0;
		end else begin
			if (ps_phase == P_IDLE) begin
				return;
			end
			if (ps_pos != 16'hFFFF) begin
				ps_pos++;
			end
		end

		case (ps_phase)
			P_SPACE: begin
				if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
					return;
				end
				if (c == CH_MINUS || c == CH_PLUS) begin
					ps_neg   = (c == CH_MINUS);
					ps_phase = P_SIGN;
				end else begin
					begin_number(c);
				end
			end
			P_SIGN: begin
				begin_number(c);
			end
			P_ZERO: begin
				// prefix letter: accumulator parks its offset for a dangling prefix
				if ((c == CH_LC_X || c == CH_UC_X) &&
				    (ps_radix == RADIX_AUTO || ps_radix == RADIX_HEX)) begin
					ps_radix = RADIX_HEX;
					ps_acc   = 32'(ps_pos);
					ps_phase = P_PREFIX;
				end else if ((c == CH_LC_B || c == CH_UC_B) &&
				             (ps_radix == RADIX_AUTO || ps_radix == RADIX_BIN)) begin
					ps_radix = RADIX_BIN;
					ps_acc   = 32'(ps_pos);
					ps_phase = P_PREFIX;
				end else begin
					if (ps_radix == RADIX_AUTO) begin
						ps_radix = RADIX_OCT;
					end
					digit_or_end(c);
				end
			end
			P_PREFIX: begin
				if (is_digit(c)) begin
					ps_acc = '0;
					accumulate(digit_val(c));
					ps_phase = P_DIGITS;
				end else begin
					// "0x"/"0b" with nothing after it parses as the zero alone
					post_result('0, 1'b0, 1'b0, ps_acc[15:0]);
				end
			end
			P_DIGITS: begin
				digit_or_end(c);
			end
			default: begin
				ps_phase = P_IDLE;
			end
		endcase
	endfunction

	// ------------------------------------------------------------------------
	// input driver: pops char_q, random gap bursts, holds payload while stalled
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall) begin
				predict_char(first_char, char_code);
			end
			if (!in_valid || !in_stall) begin
				if (in_gap != 0) begin
					in_valid <= 1'b0;
					in_gap   <= in_gap - 1;
				end else if (idle_en && $urandom_range(0, 9) == 0) begin
					in_valid <= 1'b0;
					in_gap   <= $urandom_range(0, 6);
				end else if (char_q.size() != 0) begin
					nxt         = char_q.pop_front();
					in_valid   <= 1'b1;
					first_char <= nxt.first;
					char_code  <= nxt.code;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// output stall: long hold-off on request, otherwise random bursts
	// ------------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_seen != hold_asks) begin
			hold_seen <= hold_asks;
			hold_cnt  <= HOLD_CYCLES;
			out_stall <= 1'b1;
		end else if (hold_cnt != 0) begin
			hold_cnt  <= hold_cnt - 1;
			out_stall <= 1'b1;
		end else if (out_gap != 0) begin
			out_gap   <= out_gap - 1;
			out_stall <= 1'b1;
		end else if (idle_en && $urandom_range(0, 9) == 0) begin
			out_gap   <= $urandom_range(0, 6);
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// ------------------------------------------------------------------------
	// result monitor
	// ------------------------------------------------------------------------
	task automatic flag_mismatch(string what);
		$display("%0t: mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				flag_mismatch($sformatf("unexpected result value %h", value));
			end else begin
				want = expected_results.pop_front();
				if (value !== want.value) begin
					flag_mismatch($sformatf("value %h, expected %h", value, want.value));
				end
				if (overflow !== want.overflow) begin
					flag_mismatch($sformatf("overflow %b, expected %b",
						overflow, want.overflow));
				end
				if (no_digits !== want.no_digits) begin
					flag_mismatch($sformatf("no_digits %b, expected %b",
						no_digits, want.no_digits));
				end
				if (end_offset !== want.end_offset) begin
					flag_mismatch($sformatf("end_offset %0d, expected %0d",
						end_offset, want.end_offset));
				end
			end
		end
	end

	// ------------------------------------------------------------------------
	// watchdog: any transfer on any channel resets the quiet count
	// ------------------------------------------------------------------------
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < WD_LIMIT) begin
			@(posedge clk);
			if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
			    (cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("CHECK FAILED");
		$finish;
	end

	// ------------------------------------------------------------------------
	// stimulus helpers
	// ------------------------------------------------------------------------
	task automatic add_char(logic f, logic [7:0] c);
		char_item_t it;
		it.first = f;
		it.code  = c;
		char_q.push_back(it);
	endtask

	task automatic push_text(string s);
		for (int i = 0; i < s.len(); i++) begin
			add_char(i == 0, s[i]);
		end
	endtask

	function automatic logic [7:0] digit_char(int d);
		if (d < 10) begin
			return 8'(CH_ZERO + d);
		end
		return 8'(($urandom_range(0, 1) ? CH_UC_A : CH_LC_A) + d - 10);
	endfunction

	// register write; model copy follows at the transfer
	task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [RADIX_BITS-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == REG_RADIX) begin
			radix_reg = data;
		end else if (idx == REG_SIGNED_MODE) begin
			signed_reg = data[0];
		end
	endtask

	// wait until everything is sent and answered, then let the pipe empty
	task automatic settle();
		while (char_q.size() != 0 || in_valid || expected_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// one number string for the current settings: whitespace, sign, prefix,
	// digits, terminator; open_end leaves it unterminated
	task automatic gen_number(bit open_end);
		logic [7:0]      txt[$];
		logic [7:0]      tmp[$];
		int              base;
		int              kind;
		int              nd;
		int              ws;
		longint unsigned v;

		repeat ($urandom_range(0, 3)) begin
			ws = $urandom_range(0, 5);
			txt.push_back(ws == 5 ? CH_SPACE : 8'(CH_TAB + ws));
		end
		case ($urandom_range(0, 2))
			0: txt.push_back(CH_MINUS);
			1: txt.push_back(CH_PLUS);
			default: ;
		endcase

		base = radix_reg;
		if (radix_reg == RADIX_AUTO) begin
			case ($urandom_range(0, 3))
				0: base = RADIX_DEC;
				1: begin
					txt.push_back(CH_ZERO);
					base = RADIX_OCT;
				end
				2: begin
					txt.push_back(CH_ZERO);
					txt.push_back($urandom_range(0, 1) ? CH_LC_X : CH_UC_X);
					base = RADIX_HEX;
				end
				default: begin
					txt.push_back(CH_ZERO);
					txt.push_back($urandom_range(0, 1) ? CH_LC_B : CH_UC_B);
					base = RADIX_BIN;
				end
			endcase
		end else if (radix_reg == RADIX_HEX && $urandom_range(0, 1)) begin
			txt.push_back(CH_ZERO);
			txt.push_back($urandom_range(0, 1) ? CH_LC_X : CH_UC_X);
		end else if (radix_reg == RADIX_BIN && $urandom_range(0, 1)) begin
			txt.push_back(CH_ZERO);
			txt.push_back($urandom_range(0, 1) ? CH_LC_B : CH_UC_B);
		end
		// out-of-range bases: any alphanumeric, the block should take none
		if (base < RADIX_MIN || base > RADIX_MAX) begin
			base = RADIX_MAX;
		end

		kind = $urandom_range(0, 9);
		if (kind == 0) begin
			// just around the signed and unsigned saturation points
			case ($urandom_range(0, 3))
				0: v = 64'h7FFF_FFFF;
				1: v = 64'h8000_0000;
				2: v = 64'hFFFF_FFFF;
				default: v = 64'h1_0000_0000;
			endcase
			v = v + $urandom_range(0, 2) - 1;
			do begin
				tmp.push_front(digit_char(int'(v % base)));
				v = v / base;
			end while (v != 0);
			txt = {txt, tmp};
		end else begin
			if (kind == 1) begin
				nd = $urandom_range(20, 40);   // well past any limit
			end else if (kind == 2) begin
				nd = 0;                        // sign or prefix alone
			end else begin
				nd = $urandom_range(1, 8);
			end
			repeat (nd) txt.push_back(digit_char($urandom_range(0, base - 1)));
		end

		// most strings end; the rest are cut off by the next start
		if (!open_end && $urandom_range(0, 9) != 0) begin
			case ($urandom_range(0, 3))
				0, 1: txt.push_back(CH_NUL);
				2: txt.push_back(CH_SPACE);
				default: txt.push_back(8'($urandom_range(0, 255)));
			endcase
		end
		if (txt.size() == 0) begin
			txt.push_back(CH_NUL);
		end
		foreach (txt[i]) begin
			add_char(i == 0, txt[i]);
		end
		string_items += txt.size();
	endtask

	// random bytes, mostly outside any string
	task automatic push_noise();
		repeat ($urandom_range(1, 4)) begin
			add_char($urandom_range(0, 3) == 0, 8'($urandom_range(0, 255)));
		end
	endtask

	task automatic run_phase(int budget, bit open_tail);
		string_items = 0;
		while (string_items < budget) begin
			if ($urandom_range(0, 9) == 0) begin
				push_noise();
			end else begin
				gen_number(1'b0);
			end
		end
		if (open_tail) begin
			gen_number(1'b1);
		end
	endtask

	// ------------------------------------------------------------------------
	// test sequence
	// ------------------------------------------------------------------------
	logic [5:0] phase_radix [NUM_PHASES] = '{
		RADIX_DEC, RADIX_DEC, RADIX_AUTO, RADIX_HEX, RADIX_HEX,
		RADIX_BIN, RADIX_BIN, RADIX_OCT, RADIX_MAX, RADIX_MAX,
		6'd1, 6'd37, 6'd63, 6'd3, RADIX_AUTO
	};
	logic phase_signed [NUM_PHASES] = '{
		1'b1, 1'b0, 1'b0, 1'b1, 1'b0,
		1'b1, 1'b0, 1'b1, 1'b1, 1'b0,
		1'b1, 1'b0, 1'b1, 1'b0, 1'b1
	};

	initial begin
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// directed strings under the reset settings (auto radix, signed)
		add_char(1'b0, "7");              // nothing started yet: ignored
		push_text(" \t-0x1F");            // whitespace, sign, hex prefix, mixed case
		add_char(1'b0, CH_NUL);
		push_text("0xg");                 // prefix with no hex digit after it
		push_text("12");                  // abandoned by the restart below
		push_text("0b101 ");
		push_text("+");                   // sign without digits
		add_char(1'b0, CH_NUL);
		push_text("017");                 // leading zero selects octal
		add_char(1'b0, CH_NUL);
		add_char(1'b0, "z");              // after a result: ignored
		settle();

		for (int p = 0; p < NUM_PHASES; p++) begin
			if (p == NUM_PHASES - 1) begin
				// last stretch runs with no gaps and no stalls
				idle_en <= 1'b0;
			end
			write_reg(REG_RADIX, phase_radix[p]);
			write_reg(REG_SIGNED_MODE, RADIX_BITS'(phase_signed[p]));
			// an open string now and then carries over into the next setting
			run_phase(PHASE_ITEMS, (p % 3) == 1);
			if (p == 3) begin
				// receiver holds off while the sender keeps going, so the
				// block's queue fills and in_stall has to rise
				hold_asks <= hold_asks + 1;
			end
			settle();
		end

		if (mismatches == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
